// ===== sv/stbr_pkg.sv =====
// Package for the sparing table block remap: table sizes, codes and state encoding.
package stbr_pkg;

  localparam int SPARE_ENTRIES = 1024;
  localparam int PACKET_DEPTH  = 4096;
  localparam int INDEX_WIDTH   = 11;

  localparam int SPARE_AW  = $clog2(SPARE_ENTRIES);
  localparam int PACKET_AW = $clog2(PACKET_DEPTH);
  localparam int CLR_DEPTH = (SPARE_ENTRIES > PACKET_DEPTH) ? SPARE_ENTRIES : PACKET_DEPTH;
  localparam int CLR_AW    = $clog2(CLR_DEPTH);

  localparam logic [31:0]            RESERVED_FLOOR = 32'hFFFF_FFF0;
  localparam logic [31:0]            ALL_ONES32     = 32'hFFFF_FFFF;
  localparam logic [INDEX_WIDTH-1:0] EMPTY_INDEX    = {INDEX_WIDTH{1'b1}};

  localparam logic MODE_LOAD      = 1'b0;
  localparam logic MODE_TRANSLATE = 1'b1;

  localparam logic CFG_PARTITION_ROOT = 1'b0;
  localparam logic CFG_PACKET_SHIFT   = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_TR1,
    ST_TR2
  } state_t;

endpackage

// ===== sv/sparing_table_block_remap_top.sv =====
// Sparing table block remap: spare map and packet remap tables in synchronous memories.
//
//   channel  | handshake           | payload
//   ---------+---------------------+---------------------------------------------------
//   input    | in_valid, in_stall  | mode, block, block_offset, entry_index,
//            |                     | original_location, spare_location
//   output   | out_valid, out_stall| physical_block, was_remapped, conflict, out_of_range
//   config   | cfg_we              | cfg_index, cfg_data
//
// A load word is accepted with both table reads, then checked and written back.
// A translate word is accepted with the remap read; when the remap slot holds an entry, a further
// step reads the spare location from the spare map, only after the remap read returns.
// After reset a clearing pass fills both tables with all ones, one address a cycle,
// over max(SPARE_ENTRIES, PACKET_DEPTH) addresses (4096); no word is taken meanwhile.
// The result sits in an output register, so a new word is taken while it waits; a
// stalled output holds the block in its last step until the register frees up.
module sparing_table_block_remap_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [31:0] block,
  input  logic [31:0] block_offset,
  input  logic [9:0]  entry_index,
  input  logic [31:0] original_location,
  input  logic [31:0] spare_location,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] physical_block,
  output logic        was_remapped,
  output logic        conflict,
  output logic        out_of_range,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  stbr_pkg::state_t state, state_next;

  logic [31:0] partition_root;
  logic [4:0]  packet_shift;

  // Memories.
  logic [31:0]                      spare_mem [stbr_pkg::SPARE_ENTRIES];
  logic [stbr_pkg::INDEX_WIDTH-1:0] remap_mem [stbr_pkg::PACKET_DEPTH];
  logic [31:0]                      spare_q;
  logic [stbr_pkg::INDEX_WIDTH-1:0] remap_q;

  logic                             spare_re, remap_re, spare_we, remap_we;
  logic [stbr_pkg::SPARE_AW-1:0]    spare_raddr, spare_waddr;
  logic [stbr_pkg::PACKET_AW-1:0]   remap_raddr, remap_waddr;
  logic [31:0]                      spare_wdata;
  logic [stbr_pkg::INDEX_WIDTH-1:0] remap_wdata;

  logic [stbr_pkg::CLR_AW-1:0] clr_cnt;

  // Word held while it is worked on.
  logic [31:0]                      sum_r;
  logic [31:0]                      spare_loc_r;
  logic [stbr_pkg::INDEX_WIDTH-1:0] ent_val_r;
  logic [stbr_pkg::SPARE_AW-1:0]    ent_addr_r;
  logic [stbr_pkg::PACKET_AW-1:0]   pk_addr_r;
  logic                             ent_oor_r, pk_oor_r, reserved_r;

  // Incoming word decode.
  logic [31:0] in_sum, in_pk_src, in_pk, in_ent_ext;
  logic        in_accept;

  // Step results.
  logic        out_load;
  logic        out_free;
  logic [31:0] res_phys;
  logic        res_remapped, res_conflict, res_oor;
  logic [31:0] low_mask;

  assign in_accept  = in_valid && !in_stall;
  assign in_stall   = (state != stbr_pkg::ST_IDLE);
  assign in_sum     = block + block_offset;
  assign in_pk_src  = (mode == stbr_pkg::MODE_TRANSLATE) ? in_sum : original_location;
  assign in_pk      = in_pk_src >> packet_shift;
  assign in_ent_ext = 32'(entry_index);
  assign out_free   = !out_valid || !out_stall;
  assign low_mask   = ~(stbr_pkg::ALL_ONES32 << packet_shift);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stbr_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partition_root <= 32'd0;
      packet_shift   <= 5'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        stbr_pkg::CFG_PARTITION_ROOT: partition_root <= cfg_data;
        stbr_pkg::CFG_PACKET_SHIFT:   packet_shift   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == stbr_pkg::ST_CLEAR) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sum_r       <= in_sum;
      spare_loc_r <= spare_location;
      ent_val_r   <= in_ent_ext[stbr_pkg::INDEX_WIDTH-1:0];
      ent_addr_r  <= in_ent_ext[stbr_pkg::SPARE_AW-1:0];
      pk_addr_r   <= in_pk[stbr_pkg::PACKET_AW-1:0];
      ent_oor_r   <= (in_ent_ext >= 32'(stbr_pkg::SPARE_ENTRIES));
      pk_oor_r    <= (in_pk >= 32'(stbr_pkg::PACKET_DEPTH));
      reserved_r  <= (original_location >= stbr_pkg::RESERVED_FLOOR);
    end
  end

  always_ff @(posedge clk) begin
    if (spare_we) begin
      spare_mem[spare_waddr] <= spare_wdata;
    end
    if (spare_re) begin
      spare_q <= spare_mem[spare_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (remap_we) begin
      remap_mem[remap_waddr] <= remap_wdata;
    end
    if (remap_re) begin
      remap_q <= remap_mem[remap_raddr];
    end
  end

  always_comb begin
    state_next   = state;
    spare_re     = 1'b0;
    remap_re     = 1'b0;
    spare_we     = 1'b0;
    remap_we     = 1'b0;
    spare_raddr  = ent_addr_r;
    remap_raddr  = in_pk[stbr_pkg::PACKET_AW-1:0];
    spare_waddr  = ent_addr_r;
    remap_waddr  = pk_addr_r;
    spare_wdata  = spare_loc_r;
    remap_wdata  = ent_val_r;
    out_load     = 1'b0;
    res_phys     = 32'd0;
    res_remapped = 1'b0;
    res_conflict = 1'b0;
    res_oor      = 1'b0;
    case (state)
      stbr_pkg::ST_CLEAR: begin
        spare_waddr = clr_cnt[stbr_pkg::SPARE_AW-1:0];
        remap_waddr = clr_cnt[stbr_pkg::PACKET_AW-1:0];
        spare_wdata = stbr_pkg::ALL_ONES32;
        remap_wdata = stbr_pkg::EMPTY_INDEX;
        spare_we    = (32'(clr_cnt) < 32'(stbr_pkg::SPARE_ENTRIES));
        remap_we    = (32'(clr_cnt) < 32'(stbr_pkg::PACKET_DEPTH));
        if (32'(clr_cnt) == 32'(stbr_pkg::CLR_DEPTH - 1)) begin
          state_next = stbr_pkg::ST_IDLE;
        end
      end
      stbr_pkg::ST_IDLE: begin
        if (in_accept) begin
          remap_re = 1'b1;
          if (mode == stbr_pkg::MODE_TRANSLATE) begin
            state_next = stbr_pkg::ST_TR1;
          end else begin
            spare_re    = 1'b1;
            spare_raddr = in_ent_ext[stbr_pkg::SPARE_AW-1:0];
            state_next  = stbr_pkg::ST_LOAD;
          end
        end
      end
      stbr_pkg::ST_LOAD: begin
        if (ent_oor_r) begin
          res_oor = 1'b1;
        end else begin
          if (spare_q == stbr_pkg::ALL_ONES32) begin
            spare_we = out_free;
          end else if (spare_q != spare_loc_r) begin
            res_conflict = 1'b1;
          end
          if (!reserved_r) begin
            if (pk_oor_r) begin
              res_oor = 1'b1;
            end else if (remap_q == stbr_pkg::EMPTY_INDEX) begin
              remap_we = out_free;
            end else if (remap_q != ent_val_r) begin
              res_conflict = 1'b1;
            end
          end
        end
        if (out_free) begin
          out_load   = 1'b1;
          state_next = stbr_pkg::ST_IDLE;
        end
      end
      stbr_pkg::ST_TR1: begin
        if (pk_oor_r) begin
          res_oor = 1'b1;
          if (out_free) begin
            out_load   = 1'b1;
            state_next = stbr_pkg::ST_IDLE;
          end
        end else if (remap_q == stbr_pkg::EMPTY_INDEX) begin
          res_phys = partition_root + sum_r;
          if (out_free) begin
            out_load   = 1'b1;
            state_next = stbr_pkg::ST_IDLE;
          end
        end else if (32'(remap_q) >= 32'(stbr_pkg::SPARE_ENTRIES)) begin
          res_oor = 1'b1;
          if (out_free) begin
            out_load   = 1'b1;
            state_next = stbr_pkg::ST_IDLE;
          end
        end else begin
          // The remap slot names a sparing entry; fetch its spare location.
          spare_re    = 1'b1;
          spare_raddr = remap_q[stbr_pkg::SPARE_AW-1:0];
          state_next  = stbr_pkg::ST_TR2;
        end
      end
      stbr_pkg::ST_TR2: begin
        res_phys     = spare_q + (sum_r & low_mask);
        res_remapped = 1'b1;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = stbr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = stbr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      physical_block <= res_phys;
      was_remapped   <= res_remapped;
      conflict       <= res_conflict;
      out_of_range   <= res_oor;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the sparing table block remap: directed rows, then random words.
module tb_top;

  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_REPORTS  = 50;
  localparam int DIR_COUNT    = 21;

  typedef struct packed {
    logic [31:0] phys;
    logic        remapped;
    logic        conflict;
    logic        oor;
  } remap_result_t;

  typedef struct packed {
    logic          mode;
    logic [31:0]   blk;
    logic [31:0]   offset;
    logic [9:0]    ent;
    logic [31:0]   orig;
    logic [31:0]   spare;
    logic          typed;
    remap_result_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        mode = stbr_pkg::MODE_LOAD;
  logic [31:0] block = 32'd0;
  logic [31:0] block_offset = 32'd0;
  logic [9:0]  entry_index = 10'd0;
  logic [31:0] original_location = 32'd0;
  logic [31:0] spare_location = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] physical_block;
  logic        was_remapped;
  logic        conflict;
  logic        out_of_range;
  logic        cfg_we = 1'b0;
  logic        cfg_index = stbr_pkg::CFG_PARTITION_ROOT;
  logic [31:0] cfg_data = 32'd0;

  // Shadow copies of both tables and of the settings.
  logic [31:0]                      spare_copy [stbr_pkg::SPARE_ENTRIES];
  logic [stbr_pkg::INDEX_WIDTH-1:0] remap_copy [stbr_pkg::PACKET_DEPTH];
  logic [31:0]                      root_cfg = 32'd0;
  logic [4:0]                       shift_cfg = 5'd5;

  remap_result_t pending_results [$];
  logic [9:0]    loaded_ent [$];
  logic [31:0]   loaded_orig [$];
  int            fail_cnt = 0;
  bit            gaps_on = 1'b1;
  bit            stalls_on = 1'b1;

  // All directed rows assume the settings left by reset.
  dir_row_t dir_rows [DIR_COUNT] = '{
    '{stbr_pkg::MODE_TRANSLATE, 32'h0, 32'h0, 10'h0, 32'h0, 32'h0, 1'b1,
      '{32'h0, 1'b0, 1'b0, 1'b0}},
    '{stbr_pkg::MODE_TRANSLATE, 32'hFFFF_FFFF, 32'h0, 10'h0, 32'h0, 32'h0, 1'b1,
      '{32'h0, 1'b0, 1'b0, 1'b1}},
    '{stbr_pkg::MODE_TRANSLATE, 32'hFFFF_FFFF, 32'h1, 10'h0, 32'h0, 32'h0, 1'b1,
      '{32'h0, 1'b0, 1'b0, 1'b0}},
    '{stbr_pkg::MODE_TRANSLATE, 32'h1FFFF, 32'h0, 10'h0, 32'h0, 32'h0, 1'b1,
      '{32'h1FFFF, 1'b0, 1'b0, 1'b0}},
    '{stbr_pkg::MODE_TRANSLATE, 32'h20000, 32'h0, 10'h0, 32'h0, 32'h0, 1'b1,
      '{32'h0, 1'b0, 1'b0, 1'b1}},
    '{stbr_pkg::MODE_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h0, 32'h40, 32'h1000, 1'b1,
      '{32'h0, 1'b0, 1'b0, 1'b0}},
    '{stbr_pkg::MODE_TRANSLATE, 32'h45, 32'h0, 10'h0, 32'h0, 32'h0, 1'b1,
      '{32'h1005, 1'b1, 1'b0, 1'b0}},
    '{stbr_pkg::MODE_LOAD, 32'h0, 32'h0, 10'h0, 32'h40, 32'h1000, 1'b1,
      '{32'h0, 1'b0, 1'b0, 1'b0}},
    '{stbr_pkg::MODE_LOAD, 32'h0, 32'h0, 10'h0, 32'h40, 32'h2000, 1'b1,
      '{32'h0, 1'b0, 1'b1, 1'b0}},
    '{stbr_pkg::MODE_LOAD, 32'h0, 32'h0, 10'h1, 32'h50, 32'h3000, 1'b1,
      '{32'h0, 1'b0, 1'b1, 1'b0}},
    '{stbr_pkg::MODE_LOAD, 32'h0, 32'h0, 10'h3FF, 32'hFFFF_FFF0, 32'hFFFF_FFFE, 1'b1,
      '{32'h0, 1'b0, 1'b0, 1'b0}},
    '{stbr_pkg::MODE_LOAD, 32'h0, 32'h0, 10'h2, 32'hFFFF_FFEF, 32'h0, 1'b1,
      '{32'h0, 1'b0, 1'b0, 1'b1}},
    '{stbr_pkg::MODE_LOAD, 32'h0, 32'h0, 10'h3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{32'h0, 1'b0, 1'b0, 1'b0}},
    '{stbr_pkg::MODE_LOAD, 32'h0, 32'h0, 10'h3, 32'hFFFF_FFFF, 32'h5, 1'b1,
      '{32'h0, 1'b0, 1'b0, 1'b0}},
    '{stbr_pkg::MODE_LOAD, 32'h0, 32'h0, 10'h3FF, 32'h1FFE0, 32'h0, 1'b1,
      '{32'h0, 1'b0, 1'b1, 1'b0}},
    '{stbr_pkg::MODE_TRANSLATE, 32'h1FFFF, 32'h0, 10'h0, 32'h0, 32'h0, 1'b1,
      '{32'h1D, 1'b1, 1'b0, 1'b0}},
    '{stbr_pkg::MODE_TRANSLATE, 32'h10, 32'h30, 10'h0, 32'h0, 32'h0, 1'b0,
      '{32'h0, 1'b0, 1'b0, 1'b0}},
    '{stbr_pkg::MODE_LOAD, 32'h0, 32'h0, 10'h4, 32'h20000, 32'h7, 1'b1,
      '{32'h0, 1'b0, 1'b0, 1'b1}},
    '{stbr_pkg::MODE_LOAD, 32'h0, 32'h0, 10'h5, 32'h0, 32'h100, 1'b1,
      '{32'h0, 1'b0, 1'b0, 1'b0}},
    '{stbr_pkg::MODE_TRANSLATE, 32'h0, 32'h0, 10'h0, 32'h0, 32'h0, 1'b1,
      '{32'h100, 1'b1, 1'b0, 1'b0}},
    '{stbr_pkg::MODE_TRANSLATE, 32'hFFFF_FFFF, 32'h41, 10'h0, 32'h0, 32'h0, 1'b0,
      '{32'h0, 1'b0, 1'b0, 1'b0}}
  };

  sparing_table_block_remap_top u_top (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .mode              (mode),
    .block             (block),
    .block_offset      (block_offset),
    .entry_index       (entry_index),
    .original_location (original_location),
    .spare_location    (spare_location),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .physical_block    (physical_block),
    .was_remapped      (was_remapped),
    .conflict          (conflict),
    .out_of_range      (out_of_range),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * LIMIT_CYCLES);
    $display("RESULT: ERROR");
    $finish;
  end

  // Applies one word to the shadow tables and returns the result it should give.
  function automatic remap_result_t remap_word(input logic m, input logic [31:0] b,
      input logic [31:0] o, input logic [9:0] e, input logic [31:0] orig,
      input logic [31:0] sp);
    remap_result_t                    r;
    logic [31:0]                      sum;
    logic [31:0]                      pk;
    logic [31:0]                      low_mask;
    logic [stbr_pkg::INDEX_WIDTH-1:0] idx;
    r = '0;
    idx = stbr_pkg::INDEX_WIDTH'(e);
    low_mask = 32'((33'd1 << shift_cfg) - 33'd1);
    if (m == stbr_pkg::MODE_LOAD) begin
      if (int'(e) >= stbr_pkg::SPARE_ENTRIES) begin
        r.oor = 1'b1;
      end else begin
        if (spare_copy[e] == stbr_pkg::ALL_ONES32) begin
          spare_copy[e] = sp;
        end else if (spare_copy[e] != sp) begin
          r.conflict = 1'b1;
        end
        if (orig < stbr_pkg::RESERVED_FLOOR) begin
          pk = orig >> shift_cfg;
          if (pk >= 32'(stbr_pkg::PACKET_DEPTH)) begin
            r.oor = 1'b1;
          end else if (remap_copy[pk[stbr_pkg::PACKET_AW-1:0]] == stbr_pkg::EMPTY_INDEX) begin
            remap_copy[pk[stbr_pkg::PACKET_AW-1:0]] = idx;
          end else if (remap_copy[pk[stbr_pkg::PACKET_AW-1:0]] != idx) begin
            r.conflict = 1'b1;
          end
        end
      end
    end else begin
      sum = b + o;
      pk = sum >> shift_cfg;
      if (pk >= 32'(stbr_pkg::PACKET_DEPTH)) begin
        r.oor = 1'b1;
      end else begin
        idx = remap_copy[pk[stbr_pkg::PACKET_AW-1:0]];
        if (idx == stbr_pkg::EMPTY_INDEX) begin
          r.phys = root_cfg + sum;
        end else if (32'(idx) >= 32'(stbr_pkg::SPARE_ENTRIES)) begin
          r.oor = 1'b1;
        end else begin
          r.phys = spare_copy[idx[stbr_pkg::SPARE_AW-1:0]] + (sum & low_mask);
          r.remapped = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic send_word(input logic m, input logic [31:0] b, input logic [31:0] o,
      input logic [9:0] e, input logic [31:0] orig, input logic [31:0] sp,
      input logic typed, input remap_result_t golden);
    remap_result_t want;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    block <= b;
    block_offset <= o;
    entry_index <= e;
    original_location <= orig;
    spare_location <= sp;
    do @(posedge clk); while (in_stall !== 1'b0);
    want = remap_word(m, b, o, e, orig, sp);
    pending_results.push_back(typed ? golden : want);
  endtask

  task automatic write_settings(input logic [31:0] root, input logic [4:0] shift);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= stbr_pkg::CFG_PARTITION_ROOT;
    cfg_data <= root;
    @(posedge clk);
    cfg_index <= stbr_pkg::CFG_PACKET_SHIFT;
    cfg_data <= {27'd0, shift};
    @(posedge clk);
    cfg_we <= 1'b0;
    root_cfg = root;
    shift_cfg = shift;
  endtask

  // Receiver back-pressure in bursts.
  initial begin
    forever begin
      @(posedge clk);
      if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    remap_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS) $error("result word arrived with none pending");
      end else begin
        want = pending_results.pop_front();
        if (physical_block !== want.phys) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $error("physical_block: expected %h, got %h", want.phys, physical_block);
        end
        if (was_remapped !== want.remapped) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $error("was_remapped: expected %b, got %b", want.remapped, was_remapped);
        end
        if (conflict !== want.conflict) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $error("conflict: expected %b, got %b", want.conflict, conflict);
        end
        if (out_of_range !== want.oor) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $error("out_of_range: expected %b, got %b", want.oor, out_of_range);
        end
      end
    end
  end

  initial begin
    logic [31:0]   b;
    logic [31:0]   o;
    logic [31:0]   orig;
    logic [31:0]   sp;
    logic [31:0]   target;
    logic [31:0]   low_mask;
    logic [31:0]   root_v;
    logic [9:0]    e;
    logic          m;
    logic [4:0]    shift_v;
    longint        max_pk;
    int            kind;
    int            pick;
    int            n_items;
    remap_result_t none;
    none = '0;
    for (int k = 0; k < stbr_pkg::SPARE_ENTRIES; k++)
      spare_copy[k[stbr_pkg::SPARE_AW-1:0]] = stbr_pkg::ALL_ONES32;
    for (int k = 0; k < stbr_pkg::PACKET_DEPTH; k++)
      remap_copy[k[stbr_pkg::PACKET_AW-1:0]] = stbr_pkg::EMPTY_INDEX;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_COUNT; i++) begin
      send_word(dir_rows[i].mode, dir_rows[i].blk, dir_rows[i].offset, dir_rows[i].ent,
                dir_rows[i].orig, dir_rows[i].spare, dir_rows[i].typed, dir_rows[i].res);
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          root_v = stbr_pkg::ALL_ONES32;
          shift_v = 5'd0;
        end
        1: begin
          root_v = $urandom;
          shift_v = 5'd16;
        end
        2: begin
          root_v = 32'd0;
          shift_v = 5'd31;
        end
        3: begin
          root_v = $urandom;
          shift_v = 5'($urandom_range(1, 15));
        end
        4: begin
          root_v = $urandom;
          shift_v = 5'd5;
        end
        default: begin
          root_v = $urandom;
          shift_v = 5'($urandom_range(0, 16));
        end
      endcase
      write_settings(root_v, shift_v);
      n_items = (ph == 2) ? 100 : 230;
      // The last stretch runs at full rate on both sides.
      gaps_on = (ph != 5);
      stalls_on = (ph != 5);
      loaded_ent.delete();
      loaded_orig.delete();
      low_mask = 32'((33'd1 << shift_v) - 33'd1);
      max_pk = 64'hFFFF_FFEF >> shift_v;
      if (max_pk > stbr_pkg::PACKET_DEPTH - 1) max_pk = stbr_pkg::PACKET_DEPTH - 1;

      repeat (n_items) begin
        kind = $urandom_range(0, 99);
        m = stbr_pkg::MODE_LOAD;
        b = $urandom;
        o = $urandom;
        e = 10'($urandom);
        orig = $urandom;
        sp = $urandom;
        if (kind < 30) begin
          // Well-formed load into a packet that exists in the remap table.
          orig = (32'($urandom_range(0, int'(max_pk))) << shift_v) | ($urandom & low_mask);
          pick = $urandom_range(0, 9);
          if (pick == 0) begin
            sp = stbr_pkg::ALL_ONES32;
          end else if (pick == 1) begin
            sp = 32'd0;
          end else if (pick < 4 && spare_copy[e] != stbr_pkg::ALL_ONES32) begin
            sp = spare_copy[e];
          end
          loaded_ent.push_back(e);
          loaded_orig.push_back(orig);
        end else if (kind < 38 && loaded_ent.size() > 0) begin
          // Same entry again, matching what the tables already hold.
          pick = $urandom_range(0, loaded_ent.size() - 1);
          e = loaded_ent[pick];
          orig = loaded_orig[pick];
          sp = spare_copy[e];
        end else if (kind < 42) begin
          orig = $urandom_range(stbr_pkg::RESERVED_FLOOR, stbr_pkg::ALL_ONES32);
        end else if (kind >= 46) begin
          m = stbr_pkg::MODE_TRANSLATE;
          if (kind < 80 && loaded_orig.size() > 0) begin
            pick = $urandom_range(0, loaded_orig.size() - 1);
            target = ((loaded_orig[pick] >> shift_v) << shift_v) | ($urandom & low_mask);
          end else if (kind < 94) begin
            target = (32'($urandom_range(0, int'(max_pk))) << shift_v) |
                     ($urandom & low_mask);
          end else begin
            target = $urandom;
          end
          o = target - b;
        end
        send_word(m, b, o, e, orig, sp, 1'b0, none);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
